>>> rtl/hmrt_pkg.sv
package hmrt_pkg;

	localparam int NumFields = 4;
	localparam int LayoutWidth = 63;
	localparam int CfgIndexWidth = 3;

	// field order in captured words and results
	localparam int FldButtons = 0;
	localparam int FldX = 1;
	localparam int FldY = 2;
	localparam int FldWheel = 3;

	// configuration register indexes
	localparam logic [CfgIndexWidth-1:0] CFG_REPORT_ID = 3'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_BUTTONS = 3'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_X = 3'd2;
	localparam logic [CfgIndexWidth-1:0] CFG_Y = 3'd3;
	localparam logic [CfgIndexWidth-1:0] CFG_WHEEL = 3'd4;

	localparam logic [7:0] COUNT_MAX = 8'hFF;
	localparam logic [5:0] MAX_BITS = 6'd32;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_UNDEF = 2'd1,
		ST_SHORT = 2'd2,
		ST_WIDE = 2'd3
	} status_t;

	// packed field layout, bit 0 is defined
	typedef struct packed {
		logic [19:0] post_bias;
		logic [23:0] pre_bias;
		logic [5:0] field_bits;
		logic [2:0] bit_off;
		logic [7:0] byte_off;
		logic sign_ext;
		logic defined;
	} layout_t;

	// finished report handed from capture to translation
	typedef struct packed {
		logic [NumFields-1:0][31:0] words;
		logic [7:0] length;
	} report_t;

	typedef struct packed {
		status_t status;
		logic [31:0] value;
	} field_res_t;

	typedef struct packed {
		logic ok;
		logic [NumFields-1:0][15:0] values;
		status_t [NumFields-1:0] status;
	} result_t;

	// defined check, length check, width check, mask or sign extend, add both biases
	function automatic field_res_t eval_field(layout_t l, logic [31:0] word,
			logic [7:0] length);
		logic [11:0] need;
		logic [11:0] have;
		logic [31:0] mask;
		logic [31:0] fld;
		field_res_t r;
		r.status = ST_OK;
		r.value = '0;
		need = {1'b0, l.byte_off, 3'b000} + 12'(l.bit_off) + 12'(l.field_bits);
		have = {1'b0, length, 3'b000};
		mask = 32'hFFFF_FFFF >> (MAX_BITS - l.field_bits);
		if (l.sign_ext && word[5'(l.field_bits - 6'd1)]) begin
			fld = word | ~mask;
		end else begin
			fld = word & mask;
		end
		if (!l.defined) begin
			r.status = ST_UNDEF;
		end else if (need > have) begin
			r.status = ST_SHORT;
		end else if (l.field_bits == 6'd0) begin
			r.status = ST_OK;
		end else if (l.field_bits > MAX_BITS) begin
			r.status = ST_WIDE;
		end else begin
			r.value = fld + {{8{l.pre_bias[23]}}, l.pre_bias}
				+ {{12{l.post_bias[19]}}, l.post_bias};
		end
		return r;
	endfunction

endpackage

>>> rtl/hid_mouse_report_translator.sv
// A result passes the finished report register, then the result register, after the last byte is taken.
// Throughput: one report byte per cycle; capture and translation stages overlap.
// The capture stage stalls only when a finished report cannot move into the
// result register; a held result blocks at most one more report end.
// Reset (arst_n low, asynchronous) clears config, byte count, captured words, valids.
module hid_mouse_report_translator
	import hmrt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CfgIndexWidth-1:0] cfg_index,
	input logic [LayoutWidth-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] report_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic report_ok,
	output logic [7:0] buttons,
	output logic signed [15:0] x_motion,
	output logic signed [15:0] y_motion,
	output logic signed [15:0] wheel_motion,
	output logic [1:0] buttons_status,
	output logic [1:0] x_status,
	output logic [1:0] y_status,
	output logic [1:0] wheel_status
);

	logic rid_q;
	layout_t [NumFields-1:0] layout_q;

	logic rep_valid;
	logic rep_ready;
	report_t rep;
	result_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rid_q <= 1'b0;
			layout_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REPORT_ID: rid_q <= cfg_data[0];
				CFG_BUTTONS: layout_q[FldButtons] <= layout_t'(cfg_data);
				CFG_X: layout_q[FldX] <= layout_t'(cfg_data);
				CFG_Y: layout_q[FldY] <= layout_t'(cfg_data);
				CFG_WHEEL: layout_q[FldWheel] <= layout_t'(cfg_data);
				default: ;
			endcase
		end
	end

	hmrt_capture u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.rid(rid_q),
		.layouts(layout_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.report_byte(report_byte),
		.last_byte(last_byte),
		.rep_valid(rep_valid),
		.rep_ready(rep_ready),
		.rep(rep)
	);

	hmrt_translate u_translate (
		.clk(clk),
		.arst_n(arst_n),
		.layouts(layout_q),
		.rep_valid(rep_valid),
		.rep_ready(rep_ready),
		.rep(rep),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res)
	);

	// result fields
	assign report_ok = res.ok;
	assign buttons = res.values[FldButtons][7:0];
	assign x_motion = res.values[FldX];
	assign y_motion = res.values[FldY];
	assign wheel_motion = res.values[FldWheel];
	assign buttons_status = res.status[FldButtons];
	assign x_status = res.status[FldX];
	assign y_status = res.status[FldY];
	assign wheel_status = res.status[FldWheel];

`ifndef SYNTH
	// ok flag low only when some field was too wide
	a_ok_low_needs_wide: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !report_ok |-> (buttons_status == ST_WIDE ||
			x_status == ST_WIDE || y_status == ST_WIDE || wheel_status == ST_WIDE))
		else $error("report_ok low without a too-wide field");

	// any too-wide field clears the ok flag
	a_wide_clears_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (buttons_status == ST_WIDE || x_status == ST_WIDE ||
			y_status == ST_WIDE || wheel_status == ST_WIDE) |-> !report_ok)
		else $error("too-wide field with report_ok high");

	// failed x field gives zero motion
	a_x_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && x_status != ST_OK |-> x_motion == 16'sd0)
		else $error("x motion nonzero on failed field");

	// undefined x layout reports not defined
	a_x_undef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !layout_q[FldX].defined |-> x_status == ST_UNDEF)
		else $error("x status disagrees with layout");
`endif

endmodule

>>> rtl/hmrt_capture.sv
module hmrt_capture
	import hmrt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rid,
	input layout_t [NumFields-1:0] layouts,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] report_byte,
	input logic last_byte,
	output logic rep_valid,
	input logic rep_ready,
	output report_t rep
);

	logic [7:0] count_q;
	logic [NumFields-1:0][31:0] words_q;
	logic rep_valid_s1;
	report_t rep_s1;

	logic accept;
	logic cap_en;
	logic [7:0] idx;
	logic [7:0] count_nxt;
	logic [NumFields-1:0][31:0] words_nxt;

	assign in_ready = !rep_valid_s1 || rep_ready;
	assign accept = in_valid && in_ready;
	assign rep_valid = rep_valid_s1;
	assign rep = rep_s1;

	// byte position after the report id, count saturates
	assign cap_en = (count_q != COUNT_MAX) && !(rid && count_q == 8'd0);
	assign idx = count_q - {7'd0, rid};
	assign count_nxt = (count_q != COUNT_MAX) ? count_q + 8'd1 : count_q;

	// drop the byte into each field window it falls in
	always_comb begin
		logic [7:0] diff;
		for (int f = 0; f < NumFields; f++) begin
			diff = idx - layouts[f].byte_off;
			words_nxt[f] = words_q[f];
			if (cap_en && idx >= layouts[f].byte_off && diff[7:2] == 6'd0) begin
				words_nxt[f] = words_q[f] | (32'(report_byte) << {diff[1:0], 3'b000});
			end
		end
	end

	// running capture state, cleared at end of each report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			words_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				words_q <= '0;
			end else begin
				count_q <= count_nxt;
				words_q <= words_nxt;
			end
		end
	end

	// finished report stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			rep_valid_s1 <= 1'b1;
		end else if (rep_ready) begin
			rep_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			rep_s1.words <= words_nxt;
			rep_s1.length <= count_nxt - {7'd0, rid};
		end
	end

endmodule

>>> rtl/hmrt_translate.sv
module hmrt_translate
	import hmrt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input layout_t [NumFields-1:0] layouts,
	input logic rep_valid,
	output logic rep_ready,
	input report_t rep,
	output logic out_valid,
	input logic out_ready,
	output result_t res
);

	logic out_valid_q;
	result_t res_q;
	result_t res_nxt;

	assign rep_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res = res_q;

	// evaluate fields in order; first too-wide field zeroes it and the rest
	always_comb begin
		field_res_t fr;
		logic ok;
		ok = 1'b1;
		res_nxt = '0;
		for (int f = 0; f < NumFields; f++) begin
			fr = eval_field(layouts[f], rep.words[f], rep.length);
			if (fr.status == ST_WIDE) begin
				ok = 1'b0;
			end
			res_nxt.status[f] = fr.status;
			res_nxt.values[f] = ok ? fr.value[15:0] : 16'd0;
		end
		res_nxt.ok = ok;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rep_ready) begin
			out_valid_q <= rep_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_valid && rep_ready) begin
			res_q <= res_nxt;
		end
	end

endmodule
